@@ rtl/spvm_pkg.sv @@
// spvm_pkg: shared types, constants and operation codes for the voice mixer
// no dependencies
`timescale 1ns / 1ps

package spvm_pkg;

    localparam int VOICES        = 16;
    localparam int VOICE_BITS    = 4;
    localparam int SAMPLE_WORDS  = 65536;
    localparam int ADDR_BITS     = 16;
    localparam int FRACTION_BITS = 16;
    // one guard bit above the frame index so a step past the buffer end is kept
    localparam int POS_BITS      = 17 + FRACTION_BITS;
    localparam int GAIN_SHIFT    = FRACTION_BITS + 14;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    // per-voice parameters held in one memory word
    typedef struct packed {
        logic [15:0] base;
        logic [15:0] length;
        logic [15:0] loop_first;
        logic [15:0] loop_last;
        logic        loop_en;
        logic        stereo;
        logic [23:0] rate;
        logic [15:0] gain_l;
        logic [15:0] gain_r;
    } voice_par_t;

    localparam int PAR_BITS = $bits(voice_par_t);

endpackage

@@ rtl/spvm_ram.sv @@
// spvm_ram: generic single-port-write, single-read synchronous ram
// no dependencies; read data registered
`timescale 1ns / 1ps

module spvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spvm_divmod.sv @@
// spvm_divmod: restoring remainder unit, one quotient bit per cycle
// depends on spvm_pkg
`timescale 1ns / 1ps

module spvm_divmod
    import spvm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [POS_BITS-1:0] dividend,
    input  logic [POS_BITS-1:0] divisor,
    output logic                done,
    output logic [POS_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(POS_BITS + 1);

    logic [POS_BITS-1:0] rem_reg, rem_next;
    logic [POS_BITS-1:0] quo_reg, quo_next;
    logic [POS_BITS-1:0] div_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [POS_BITS:0]   trial;

    // load on start, otherwise one shift-subtract step
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[POS_BITS-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_BITS'(POS_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[POS_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = POS_BITS'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[POS_BITS-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign done      = busy_reg && cnt_reg == CNT_BITS'(1);
    assign remainder = rem_next;

endmodule

@@ rtl/sample_playback_voice_mixer_top.sv @@
// sample_playback_voice_mixer_top: voice mixer with linear interpolation
// every beat gives one result beat; set first reads and rewrites the voice parameters;
// the next beat is taken the cycle after the result beat leaves
// tick: voices are visited in turn; an idle one is skipped, an ending one retired;
// mono reads two words, stereo four; a loop wrap runs the 33-step remainder unit.
// reset: synchronous active-low aresetn clears voice activity and the sequencer;
// depends on spvm_pkg, spvm_ram, spvm_divmod
`timescale 1ns / 1ps

module sample_playback_voice_mixer_top
    import spvm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [3:0]         s_voice,
    input  logic [15:0]        s_address,
    input  logic signed [15:0] s_sample_value,
    input  logic [15:0]        s_frame_count,
    input  logic [15:0]        s_loop_first,
    input  logic [15:0]        s_loop_last,
    input  logic               s_loop_enable,
    input  logic               s_stereo,
    input  logic [23:0]        s_step,
    input  logic [15:0]        s_gain_left,
    input  logic [15:0]        s_gain_right,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_out,
    output logic signed [15:0] m_right_out,
    output logic               m_clipped,
    output logic               m_voice_playing
);

    localparam int ACC_BITS = 56;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_PRD   = 5'd1;
    localparam logic [4:0] ST_SETW  = 5'd2;
    localparam logic [4:0] ST_TVIS  = 5'd3;
    localparam logic [4:0] ST_TPAR  = 5'd4;
    localparam logic [4:0] ST_TWIN  = 5'd5;
    localparam logic [4:0] ST_TDIV  = 5'd6;
    localparam logic [4:0] ST_TFRM  = 5'd7;
    localparam logic [4:0] ST_RD0   = 5'd8;
    localparam logic [4:0] ST_RD1   = 5'd9;
    localparam logic [4:0] ST_RD2   = 5'd10;
    localparam logic [4:0] ST_RD3   = 5'd11;
    localparam logic [4:0] ST_RDW   = 5'd12;
    localparam logic [4:0] ST_INTL  = 5'd13;
    localparam logic [4:0] ST_INTR  = 5'd14;
    localparam logic [4:0] ST_GAINL = 5'd15;
    localparam logic [4:0] ST_GAINR = 5'd16;
    localparam logic [4:0] ST_NEXT  = 5'd17;
    localparam logic [4:0] ST_FIN   = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;
    localparam logic [4:0] ST_TCHK  = 5'd20;

    logic [4:0] state_reg, state_next;

    // captured beat
    logic [2:0]  op_reg;
    logic [3:0]  vc_reg;
    logic [15:0] g_l_reg, g_r_reg;
    logic        le_reg;
    logic [23:0] step_reg;

    logic [VOICES-1:0] active_reg;

    // memories
    logic                 smem_we;
    logic [ADDR_BITS-1:0] smem_waddr, smem_raddr;
    logic [15:0]          smem_rdata;
    logic                 par_we;
    logic [VOICE_BITS-1:0] par_addr_w, par_addr_r;
    voice_par_t           par_wdata, par_rdata;
    logic                 pos_we;
    logic [VOICE_BITS-1:0] pos_addr_w, pos_addr_r;
    logic [POS_BITS-1:0]  pos_wdata, pos_rdata;

    spvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_smem (
        .aclk(aclk), .we(smem_we), .waddr(smem_waddr), .wdata(s_sample_value),
        .raddr(smem_raddr), .rdata(smem_rdata));

    spvm_ram #(.WIDTH(PAR_BITS), .DEPTH(VOICES)) u_par (
        .aclk(aclk), .we(par_we), .waddr(par_addr_w), .wdata(par_wdata),
        .raddr(par_addr_r), .rdata(par_rdata));

    spvm_ram #(.WIDTH(POS_BITS), .DEPTH(VOICES)) u_pos (
        .aclk(aclk), .we(pos_we), .waddr(pos_addr_w), .wdata(pos_wdata),
        .raddr(pos_addr_r), .rdata(pos_rdata));

    // tick working registers
    voice_par_t          par_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [16:0]         ls_reg, le_w_reg, end_reg;
    logic [15:0]         frame_reg, nxt_reg;
    logic signed [16:0]  a0_reg, a1_reg, b0_reg, b1_reg;
    logic signed [33:0]  l_reg, r_reg;
    logic signed [ACC_BITS-1:0] acc_l_reg, acc_r_reg;
    logic [1:0]          rd_cnt_reg;

    // result register
    logic               out_valid_reg;
    logic signed [15:0] out_l_reg, out_r_reg;
    logic               out_clip_reg, out_play_reg;

    // remainder unit for loop wrap
    logic                div_start;
    logic                div_done;
    logic [POS_BITS-1:0] div_rem;
    logic [POS_BITS-1:0] span_w, over_w;

    assign span_w = POS_BITS'(le_w_reg - ls_reg) << FRACTION_BITS;
    assign over_w = pos_reg - (POS_BITS'(le_w_reg) << FRACTION_BITS);

    spvm_divmod u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(over_w), .divisor(span_w), .done(div_done), .remainder(div_rem));

    // end of buffer or loop window reached, and whether it wraps
    logic        past_end_w, wrap_w;
    logic [15:0] pos_frame_w;

    assign past_end_w  = pos_reg >= (POS_BITS'(end_reg) << FRACTION_BITS);
    assign wrap_w      = par_reg.loop_en && le_w_reg > ls_reg;
    assign pos_frame_w = pos_reg[FRACTION_BITS +: 16];

    // sample address per read slot
    logic [15:0] rd_off;
    always_comb begin
        case (rd_cnt_reg)
            2'd0:    rd_off = par_reg.stereo ? {frame_reg[14:0], 1'b0} : frame_reg;
            2'd1:    rd_off = par_reg.stereo ? {nxt_reg[14:0], 1'b0} : nxt_reg;
            2'd2:    rd_off = {frame_reg[14:0], 1'b1};
            default: rd_off = {nxt_reg[14:0], 1'b1};
        endcase
    end

    assign smem_raddr = ADDR_BITS'(par_reg.base + rd_off);
    assign smem_we    = state_reg == ST_IDLE && s_valid && s_ready && s_operation == OP_WRITE;
    assign smem_waddr = ADDR_BITS'(s_address);

    // interpolation helpers
    logic signed [16:0]  diff_w;
    logic signed [33:0]  interp_w;
    logic signed [33:0]  gsrc_w;
    logic signed [16:0]  gain_w;
    logic signed [51:0]  prod_w;
    logic [FRACTION_BITS-1:0] frac_w;
    logic signed [ACC_BITS-1:0] rnd_l, rnd_r, sh_l, sh_r;

    assign frac_w   = pos_reg[FRACTION_BITS-1:0];
    assign diff_w   = (state_reg == ST_INTL) ? a1_reg - a0_reg : b1_reg - b0_reg;
    assign interp_w = ((state_reg == ST_INTL) ? (34'(a0_reg) <<< FRACTION_BITS)
                                               : (34'(b0_reg) <<< FRACTION_BITS))
                      + 34'(diff_w) * $signed({1'b0, frac_w});
    assign gsrc_w   = (state_reg == ST_GAINL) ? l_reg : r_reg;
    assign gain_w   = (state_reg == ST_GAINL) ? $signed({1'b0, par_reg.gain_l})
                                               : $signed({1'b0, par_reg.gain_r});
    assign prod_w   = 52'(gsrc_w) * 52'(gain_w);
    assign rnd_l    = acc_l_reg + (ACC_BITS'(1) <<< (GAIN_SHIFT - 1));
    assign rnd_r    = acc_r_reg + (ACC_BITS'(1) <<< (GAIN_SHIFT - 1));
    assign sh_l     = rnd_l >>> GAIN_SHIFT;
    assign sh_r     = rnd_r >>> GAIN_SHIFT;

    function automatic logic [16:0] sat16(input logic signed [ACC_BITS-1:0] v);
        logic [16:0] r;
        begin
            if (v > 56'sd32767) begin
                r = {1'b1, 16'h7FFF};
            end else if (v < -56'sd32768) begin
                r = {1'b1, 16'h8000};
            end else begin
                r = {1'b0, v[15:0]};
            end
            return r;
        end
    endfunction

    logic [16:0] sat_l, sat_r;
    assign sat_l = sat16(sh_l);
    assign sat_r = sat16(sh_r);

    assign s_ready = state_reg == ST_IDLE && !out_valid_reg;

    // memory port control
    logic [16:0] len17;
    always_comb begin
        len17      = {1'b0, par_rdata.length};
        par_we     = 1'b0;
        par_addr_w = vc_reg;
        par_addr_r = (state_reg == ST_IDLE) ? s_voice : vc_reg;
        par_wdata  = par_rdata;
        pos_we     = 1'b0;
        pos_addr_w = vc_reg;
        pos_addr_r = vc_reg;
        pos_wdata  = '0;
        div_start  = 1'b0;
        if (state_reg == ST_IDLE && s_valid && s_ready && s_operation == OP_START) begin
            par_we     = 1'b1;
            par_addr_w = s_voice;
            par_wdata  = '{base: s_address, length: s_frame_count,
                           loop_first: s_loop_first, loop_last: s_loop_last,
                           loop_en: s_loop_enable, stereo: s_stereo, rate: s_step,
                           gain_l: s_gain_left, gain_r: s_gain_right};
            pos_we     = 1'b1;
            pos_addr_w = s_voice;
        end
        if (state_reg == ST_SETW) begin
            par_we            = 1'b1;
            par_wdata.loop_en = le_reg;
            par_wdata.rate    = step_reg;
            par_wdata.gain_l  = g_l_reg;
            par_wdata.gain_r  = g_r_reg;
        end
        // only a voice still playing advances its position
        if (state_reg == ST_NEXT) begin
            pos_we    = active_reg[vc_reg];
            pos_wdata = pos_reg + POS_BITS'((par_reg.rate == '0) ? 24'd1 : par_reg.rate);
        end
        if (state_reg == ST_TDIV && rd_cnt_reg == 2'd0) begin
            div_start = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_operation)
                        OP_SET:  state_next = ST_PRD;
                        OP_TICK: state_next = ST_TVIS;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_PRD:   state_next = ST_SETW;
            ST_SETW:  state_next = ST_OUT;
            ST_TVIS:  state_next = active_reg[vc_reg] ? ST_TPAR : ST_NEXT;
            ST_TPAR:  state_next = ST_TWIN;
            ST_TWIN:  state_next = ST_TCHK;
            ST_TCHK: begin
                // empty buffer or past the end: wrap or retire; else go on to the frame
                if (par_reg.length == 16'd0) begin
                    state_next = ST_NEXT;
                end else if (past_end_w) begin
                    state_next = wrap_w ? ST_TDIV : ST_NEXT;
                end else begin
                    state_next = ST_TFRM;
                end
            end
            ST_TDIV:  state_next = div_done ? ST_TFRM : ST_TDIV;
            ST_TFRM:  state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = par_reg.stereo ? ST_RD2 : ST_RDW;
            ST_RD2:   state_next = ST_RD3;
            ST_RD3:   state_next = ST_RDW;
            ST_RDW:   state_next = ST_INTL;
            ST_INTL:  state_next = ST_INTR;
            ST_INTR:  state_next = ST_GAINL;
            ST_GAINL: state_next = ST_GAINR;
            ST_GAINR: state_next = ST_NEXT;
            ST_NEXT:  state_next = (vc_reg == VOICE_BITS'(VOICES - 1)) ? ST_FIN : ST_TVIS;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg   <= s_operation;
                        vc_reg   <= (s_operation == OP_TICK) ? '0 : s_voice;
                        le_reg   <= s_loop_enable;
                        step_reg <= s_step;
                        g_l_reg  <= s_gain_left;
                        g_r_reg  <= s_gain_right;
                        acc_l_reg <= '0;
                        acc_r_reg <= '0;
                        out_clip_reg <= 1'b0;
                        out_l_reg <= '0;
                        out_r_reg <= '0;
                        out_play_reg <= active_reg[s_voice];
                        if (s_operation == OP_START) begin
                            active_reg[s_voice] <= s_frame_count != 16'd0;
                        end
                        if (s_operation == OP_STOP) begin
                            active_reg[s_voice] <= 1'b0;
                        end
                    end
                end
                ST_TPAR: begin
                    par_reg <= par_rdata;
                    pos_reg <= pos_rdata;
                    if (par_rdata.loop_last > par_rdata.loop_first) begin
                        ls_reg   <= (par_rdata.loop_first < par_rdata.length - 16'd1)
                                    ? {1'b0, par_rdata.loop_first}
                                    : {1'b0, par_rdata.length - 16'd1};
                        le_w_reg <= (par_rdata.loop_last < par_rdata.length)
                                    ? {1'b0, par_rdata.loop_last} : len17;
                    end else begin
                        ls_reg   <= '0;
                        le_w_reg <= len17;
                    end
                end
                ST_TWIN: begin
                    end_reg <= par_reg.loop_en ? le_w_reg : {1'b0, par_reg.length};
                end
                ST_TCHK: begin
                    // empty buffer or past the end: wrap or retire
                    if (par_reg.length == 16'd0) begin
                        active_reg[vc_reg] <= 1'b0;
                    end else if (past_end_w) begin
                        if (wrap_w) begin
                            rd_cnt_reg <= 2'd0;
                        end else begin
                            active_reg[vc_reg] <= 1'b0;
                        end
                    end
                end
                ST_TDIV: begin
                    rd_cnt_reg <= 2'd1;
                    if (div_done) begin
                        pos_reg <= (POS_BITS'(ls_reg) << FRACTION_BITS) + div_rem;
                    end
                end
                ST_TFRM: begin
                    frame_reg  <= pos_frame_w;
                    nxt_reg    <= ({1'b0, pos_frame_w} + 17'd1
                                   < {1'b0, par_reg.length} - 17'd1)
                                  ? pos_frame_w + 16'd1
                                  : par_reg.length - 16'd1;
                    rd_cnt_reg <= 2'd0;
                end
                ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RDW: begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (state_reg != ST_RD0) begin
                        // data of the previous slot arrives now
                        case (state_reg)
                            ST_RD1:  a0_reg <= 17'(signed'(smem_rdata));
                            ST_RD2:  a1_reg <= 17'(signed'(smem_rdata));
                            ST_RD3:  b0_reg <= 17'(signed'(smem_rdata));
                            default: begin
                                if (par_reg.stereo) begin
                                    b1_reg <= 17'(signed'(smem_rdata));
                                end else begin
                                    a1_reg <= 17'(signed'(smem_rdata));
                                end
                            end
                        endcase
                    end
                end
                ST_INTL: begin
                    l_reg <= interp_w;
                end
                ST_INTR: begin
                    r_reg <= par_reg.stereo ? interp_w : l_reg;
                end
                ST_GAINL: begin
                    acc_l_reg <= acc_l_reg + ACC_BITS'(prod_w);
                end
                ST_GAINR: begin
                    acc_r_reg <= acc_r_reg + ACC_BITS'(prod_w);
                end
                ST_NEXT: begin
                    vc_reg <= vc_reg + 1'b1;
                end
                ST_FIN: begin
                    out_l_reg    <= sat_l[15:0];
                    out_r_reg    <= sat_r[15:0];
                    out_clip_reg <= sat_l[16] | sat_r[16];
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    if (op_reg != OP_QUERY) begin
                        out_play_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_left_out      = out_l_reg;
    assign m_right_out     = out_r_reg;
    assign m_clipped       = out_clip_reg;
    assign m_voice_playing = out_play_reg;

    // checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    a_quiet_nontick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && op_reg != OP_TICK) |-> (m_left_out == '0 && m_right_out == '0 && !m_clipped))
        else $error("nonzero mix on non-tick beat");

endmodule

@@ tb/tb_sample_playback_voice_mixer_top.sv @@
// tb_sample_playback_voice_mixer_top: self-checking bench for the voice mixer, with an in-bench
// mixer model, random idling on both channels and a long output hold-off
// depends on spvm_pkg and sample_playback_voice_mixer_top
`timescale 1ns / 1ps

module tb_sample_playback_voice_mixer_top;
    import spvm_pkg::*;

    localparam int  SETTLE_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int  BEAT_TOTAL = 1550;
    localparam int  TAIL_BEATS = 200;

    // operation codes with no function
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  voice;
        logic [15:0] addr;
        logic [15:0] sval;
        logic [15:0] count;
        logic [15:0] lfirst;
        logic [15:0] llast;
        logic        lp;
        logic        st;
        logic [23:0] step;
        logic [15:0] gl;
        logic [15:0] gr;
    } beat_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        clip;
        logic        playing;
    } frame_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_operation = '0;
    logic [3:0]         s_voice = '0;
    logic [15:0]        s_address = '0;
    logic signed [15:0] s_sample_value = '0;
    logic [15:0]        s_frame_count = '0;
    logic [15:0]        s_loop_first = '0;
    logic [15:0]        s_loop_last = '0;
    logic               s_loop_enable = 1'b0;
    logic               s_stereo = 1'b0;
    logic [23:0]        s_step = '0;
    logic [15:0]        s_gain_left = '0;
    logic [15:0]        s_gain_right = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_left_out;
    logic signed [15:0] m_right_out;
    logic               m_clipped;
    logic               m_voice_playing;

    // mixer model state
    logic signed [15:0] pcm_mem [SAMPLE_WORDS];
    bit                 pcm_written [SAMPLE_WORDS];
    bit                 v_on [VOICES];
    longint unsigned    v_pos [VOICES];
    logic [15:0]        v_base [VOICES];
    logic [15:0]        v_len [VOICES];
    logic [15:0]        v_first [VOICES];
    logic [15:0]        v_last [VOICES];
    bit                 v_loop [VOICES];
    bit                 v_st [VOICES];
    logic [23:0]        v_rate [VOICES];
    logic [15:0]        v_gl [VOICES];
    logic [15:0]        v_gr [VOICES];

    frame_t pending_frames [$];
    int     errors = 0;
    int     sent_beats = 0;
    bit     idle_on = 1'b0;
    int     hold_cycles = 0;
    longint cycles = 0;

    sample_playback_voice_mixer_top dut (.*);

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // position after loop handling and the four words a voice reads this tick
    function automatic void voice_locate(input int v, output bit alive,
                                         output longint unsigned pos,
                                         output logic [15:0] adr [4]);
        longint unsigned len, first, last, ls, le, e, frame, nxt;
        len = v_len[v];
        first = v_first[v];
        last = v_last[v];
        ls = 0;
        le = len;
        pos = v_pos[v];
        alive = 1'b0;
        for (int k = 0; k < 4; k++) adr[k] = '0;
        if (len == 0) return;
        if (last > first) begin
            ls = (first < len - 1) ? first : len - 1;
            le = (last < len) ? last : len;
        end
        e = v_loop[v] ? le : len;
        if (pos >= (e << FRACTION_BITS)) begin
            if (v_loop[v] && le > ls) begin
                pos = (ls << FRACTION_BITS)
                    + (pos - (le << FRACTION_BITS)) % ((le - ls) << FRACTION_BITS);
            end else begin
                return;
            end
        end
        alive = 1'b1;
        frame = pos >> FRACTION_BITS;
        nxt = (frame + 1 < len - 1) ? frame + 1 : len - 1;
        if (v_st[v]) begin
            adr[0] = v_base[v] + 16'(frame * 2);
            adr[1] = v_base[v] + 16'(nxt * 2);
            adr[2] = v_base[v] + 16'(frame * 2 + 1);
            adr[3] = v_base[v] + 16'(nxt * 2 + 1);
        end else begin
            adr[0] = v_base[v] + 16'(frame);
            adr[1] = v_base[v] + 16'(nxt);
            adr[2] = adr[0];
            adr[3] = adr[1];
        end
    endfunction

    // round half up, drop gain and fraction bits, saturate
    function automatic logic [15:0] round_sat(input longint acc, inout bit clip);
        longint q;
        q = (acc + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        if (q > 32767) begin
            clip = 1'b1;
            return 16'h7fff;
        end
        if (q < -32768) begin
            clip = 1'b1;
            return 16'h8000;
        end
        return q[15:0];
    endfunction

    // advance the model by one beat and return the frame it answers with
    function automatic frame_t mixer_predict(input beat_t b);
        frame_t f;
        int v;
        bit alive, clip;
        longint unsigned pos, frac;
        logic [15:0] adr [4];
        longint a0, a1, b0, b1, l, r, acc_l, acc_r, g;
        f = '{default: '0};
        v = b.voice;
        case (b.op)
            OP_WRITE: begin
                pcm_mem[b.addr] = b.sval;
                pcm_written[b.addr] = 1'b1;
            end
            OP_START: begin
                v_base[v] = b.addr;
                v_len[v] = b.count;
                v_first[v] = b.lfirst;
                v_last[v] = b.llast;
                v_loop[v] = b.lp;
                v_st[v] = b.st;
                v_rate[v] = b.step;
                v_gl[v] = b.gl;
                v_gr[v] = b.gr;
                v_pos[v] = 0;
                v_on[v] = (b.count != 0);
            end
            OP_SET: begin
                v_loop[v] = b.lp;
                v_rate[v] = b.step;
                v_gl[v] = b.gl;
                v_gr[v] = b.gr;
            end
            OP_STOP: v_on[v] = 1'b0;
            OP_QUERY: f.playing = v_on[v];
            OP_TICK: begin
                acc_l = 0;
                acc_r = 0;
                clip = 1'b0;
                for (int i = 0; i < VOICES; i++) begin
                    if (v_on[i]) begin
                        voice_locate(i, alive, pos, adr);
                        if (!alive) begin
                            v_on[i] = 1'b0;
                        end else begin
                            frac = pos & ((64'd1 << FRACTION_BITS) - 1);
                            a0 = pcm_mem[adr[0]];
                            a1 = pcm_mem[adr[1]];
                            b0 = pcm_mem[adr[2]];
                            b1 = pcm_mem[adr[3]];
                            l = (a0 <<< FRACTION_BITS) + (a1 - a0) * longint'(frac);
                            r = (b0 <<< FRACTION_BITS) + (b1 - b0) * longint'(frac);
                            g = v_gl[i];
                            acc_l += l * g;
                            g = v_gr[i];
                            acc_r += r * g;
                            v_pos[i] = pos + ((v_rate[i] != 0) ? v_rate[i] : 24'd1);
                        end
                    end
                end
                f.left = round_sat(acc_l, clip);
                f.right = round_sat(acc_r, clip);
                f.clip = clip;
            end
            default: ;
        endcase
        return f;
    endfunction

    // present one beat and wait for it to be taken
    task automatic send_beat(input beat_t b);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= b.op;
        s_voice <= b.voice;
        s_address <= b.addr;
        s_sample_value <= b.sval;
        s_frame_count <= b.count;
        s_loop_first <= b.lfirst;
        s_loop_last <= b.llast;
        s_loop_enable <= b.lp;
        s_stereo <= b.st;
        s_step <= b.step;
        s_gain_left <= b.gl;
        s_gain_right <= b.gr;
        do @(posedge aclk); while (!s_ready);
        pending_frames.push_back(mixer_predict(b));
        sent_beats++;
    endtask

    task automatic input_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic beat_t blank_beat(input logic [2:0] op);
        beat_t b;
        b = '{default: '0};
        b.op = op;
        return b;
    endfunction

    task automatic send_write(input logic [15:0] a, input logic [15:0] d);
        beat_t b;
        b = blank_beat(OP_WRITE);
        b.addr = a;
        b.sval = d;
        send_beat(b);
    endtask

    // a tick only reads memory words that were written: fill any gap first
    task automatic send_tick();
        bit alive;
        longint unsigned pos;
        logic [15:0] adr [4];
        for (int i = 0; i < VOICES; i++) begin
            if (v_on[i]) begin
                voice_locate(i, alive, pos, adr);
                if (alive) begin
                    for (int k = 0; k < 4; k++) begin
                        if (!pcm_written[adr[k]]) send_write(adr[k], 16'($urandom));
                    end
                end
            end
        end
        send_beat(blank_beat(OP_TICK));
    endtask

    task automatic send_start(input int v, input logic [15:0] base, input logic [15:0] len,
                              input logic [15:0] lf, input logic [15:0] ll, input bit lp,
                              input bit st, input logic [23:0] stp,
                              input logic [15:0] gl, input logic [15:0] gr);
        beat_t b;
        b = '{OP_START, 4'(v), base, 16'($urandom), len, lf, ll, lp, st, stp, gl, gr};
        send_beat(b);
    endtask

    task automatic send_voice_op(input logic [2:0] op, input int v);
        beat_t b;
        b = '{op, 4'(v), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 1'($urandom), 1'($urandom), 24'($urandom), 16'($urandom),
              16'($urandom)};
        send_beat(b);
    endtask

    // one random beat, mostly well-formed playback traffic
    task automatic send_random_beat();
        int pick;
        logic [15:0] len, lf, ll;
        logic [23:0] stp;
        logic [15:0] gl, gr;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        lf = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        ll = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
        case ($urandom_range(0, 3))
            0: stp = 24'($urandom);
            1: stp = 24'($urandom_range(0, 3));
            default: stp = 24'($urandom_range(1, 'h3ffff));
        endcase
        gl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 'h1fff));
        gr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 'h1fff));
        if (pick < 40) begin
            send_tick();
        end else if (pick < 55) begin
            send_start($urandom_range(0, VOICES - 1), 16'($urandom), len, lf, ll,
                       1'($urandom), 1'($urandom), stp, gl, gr);
        end else if (pick < 65) begin
            send_voice_op(OP_SET, $urandom_range(0, VOICES - 1));
        end else if (pick < 70) begin
            send_voice_op(OP_STOP, $urandom_range(0, VOICES - 1));
        end else if (pick < 83) begin
            send_voice_op(OP_QUERY, $urandom_range(0, VOICES - 1));
        end else if (pick < 95) begin
            send_write(16'($urandom), 16'($urandom));
        end else begin
            send_voice_op(($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI,
                          $urandom_range(0, VOICES - 1));
        end
    endtask

    task automatic drain();
        input_quiet();
        wait (pending_frames.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // extremes, every operation and the special cases
    task automatic test_directed();
        send_write(16'h0000, 16'h7fff);
        send_write(16'hffff, 16'h8000);
        send_write(16'h0001, 16'h8000);
        send_voice_op(OP_QUERY, 0);
        send_start(0, 16'h0000, 16'h0000, 0, 0, 0, 0, 24'd1, 16'hffff, 16'hffff);
        send_voice_op(OP_QUERY, 0);
        // stereo buffer straddling the top of memory, zero step
        send_start(15, 16'hfffe, 16'd3, 16'd1, 16'd3, 1, 1, 24'd0, 16'hffff, 16'hffff);
        send_start(1, 16'h0000, 16'd2, 16'hffff, 16'h0000, 0, 0, 24'hffffff, 16'h4000,
                   16'h0000);
        send_tick();
        send_tick();
        send_voice_op(OP_QUERY, 1);
        send_voice_op(OP_QUERY, 15);
        for (int i = 2; i < 6; i++)
            send_start(i, 16'h0000, 16'd1, 0, 0, 1, 0, 24'h8000, 16'hffff, 16'hffff);
        send_tick();
        send_voice_op(OP_SET, 15);
        send_tick();
        send_voice_op(OP_STOP, 15);
        send_voice_op(OP_QUERY, 15);
        send_voice_op(OP_SPARE_LO, 3);
        send_voice_op(OP_SPARE_HI, 4);
        send_tick();
        for (int i = 0; i < VOICES; i++) send_voice_op(OP_STOP, i);
    endtask

    // loop windows of every shape, with wraps and play-once ends
    task automatic test_loop_windows();
        for (int n = 0; n < 12; n++) begin
            send_start(n, 16'($urandom), 16'($urandom_range(1, 12)),
                       16'($urandom_range(0, 14)), 16'($urandom_range(0, 16)),
                       1'($urandom), 1'($urandom), 24'($urandom_range(1, 'h50000)),
                       16'($urandom_range(0, 'h1000)), 16'($urandom_range(0, 'h1000)));
        end
        repeat (40) send_tick();
    endtask

    // output held off while beats keep coming
    task automatic test_output_hold();
        hold_cycles = 600;
        repeat (60) send_random_beat();
    endtask

    // beats counted with the memory fills that ticks bring along
    task automatic test_random_traffic();
        idle_on = 1'b1;
        while (sent_beats < BEAT_TOTAL - TAIL_BEATS) send_random_beat();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        while (sent_beats < BEAT_TOTAL) send_random_beat();
    endtask

    // output side: random stalls and the requested long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        frame_t f;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat l=%h r=%h c=%b p=%b", $time,
                         m_left_out, m_right_out, m_clipped, m_voice_playing);
            end else begin
                f = pending_frames.pop_front();
                if (f.left !== m_left_out || f.right !== m_right_out
                    || f.clip !== m_clipped || f.playing !== m_voice_playing) begin
                    errors++;
                    $display("%0t: mismatch exp l=%h r=%h c=%b p=%b got l=%h r=%h c=%b p=%b",
                             $time, f.left, f.right, f.clip, f.playing, m_left_out,
                             m_right_out, m_clipped, m_voice_playing);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < SAMPLE_WORDS; i++) begin
            pcm_mem[i] = '0;
            pcm_written[i] = 1'b0;
        end
        for (int i = 0; i < VOICES; i++) begin
            v_on[i] = 1'b0;
            v_pos[i] = 0;
            v_base[i] = '0;
            v_len[i] = '0;
            v_first[i] = '0;
            v_last[i] = '0;
            v_loop[i] = 1'b0;
            v_st[i] = 1'b0;
            v_rate[i] = '0;
            v_gl[i] = '0;
            v_gr[i] = '0;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_loop_windows();
        test_output_hold();
        test_random_traffic();
        test_back_to_back();
        drain();
        if (errors == 0 && pending_frames.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
